// ===== rtl/efl_pkg.sv =====
// ----------------------------------------------------------------------------
// Extent free list allocator package
// Shared item types, operation and status codes, and the control bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package efl_pkg;

  localparam logic [1:0] OP_FORMAT   = 2'd0;
  localparam logic [1:0] OP_ALLOCATE = 2'd1;
  localparam logic [1:0] OP_FREE     = 2'd2;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NO_SPACE      = 3'd1;
  localparam logic [2:0] ST_ALREADY_FREE  = 3'd2;
  localparam logic [2:0] ST_NOT_FORMATTED = 3'd3;
  localparam logic [2:0] ST_CHECK_FAILED  = 3'd4;
  localparam logic [2:0] ST_OUT_OF_RANGE  = 3'd5;

  localparam logic [10:0] COUNT_MAX     = 11'd2047;
  localparam logic [10:0] VOLUME_RESET  = 11'd1024;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] block_index;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  allocated_block;
    logic [2:0]  status;
    logic [10:0] free_total;
  } out_item_t;

  typedef struct packed {
    logic take_in;
    logic clear_step;
    logic read_entry;
    logic eval;
    logic write_head;
    logic format_done;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_format;
    logic clear_last;
    logic split;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/efl_dp.sv =====
// ----------------------------------------------------------------------------
// Extent free list allocator datapath
// Holds the run table memory, the list head, the free count, the volume
// register and the result registers, and carries out controller commands.
// ----------------------------------------------------------------------------
module efl_dp import efl_pkg::*; #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  output dp_stat_t   stat,
  input  in_item_t   in_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [10:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = (IW + 1 > 11) ? IW + 1 : 11;
  localparam int EW = 1 + IW + 11;
  localparam logic [CW-1:0] MAX_W  = CW'(MAX_BLOCKS);
  localparam logic [IW:0]   MAX_I  = (IW + 1)'(MAX_BLOCKS);
  localparam logic [IW-1:0] LAST_A = IW'(MAX_BLOCKS - 1);

  logic [EW-1:0] mem [MAX_BLOCKS];
  logic [EW-1:0] rdata;

  logic [10:0]   volume;
  logic          formatted;
  logic [IW-1:0] first_free;
  logic [10:0]   free_count;
  in_item_t      in_q;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] clr_cnt;
  out_item_t     res;

  logic [CW-1:0] vol_w;
  logic [CW-1:0] eff_w;
  logic [10:0]   eff;
  logic          r_mark;
  logic [IW-1:0] r_next;
  logic [10:0]   r_len;
  logic [IW:0]   nh;
  logic [2:0]    st;
  logic [IW-1:0] ff_next;
  logic [10:0]   cnt_next;
  logic          split;
  logic          we_e;
  logic [IW-1:0] wa_e;
  logic [EW-1:0] wd_e;
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [IW-1:0] raddr;

  assign vol_w = CW'(volume);
  always_comb begin
    if (vol_w < CW'(2)) begin
      eff_w = CW'(2);
    end else if (vol_w > MAX_W) begin
      eff_w = MAX_W;
    end else begin
      eff_w = vol_w;
    end
  end
  assign eff = eff_w[10:0];

  assign r_mark = rdata[EW-1];
  assign r_next = rdata[EW-2 -: IW];
  assign r_len  = rdata[10:0];
  assign nh     = {1'b0, first_free} + (IW + 1)'(1);

  always_comb begin
    st       = ST_OK;
    ff_next  = first_free;
    cnt_next = free_count;
    split    = 1'b0;
    we_e     = 1'b0;
    wa_e     = rd_addr;
    wd_e     = '0;
    unique case (in_q.op)
      OP_ALLOCATE: begin
        if (!formatted) begin
          st = ST_NOT_FORMATTED;
        end else if (first_free == '0) begin
          st = ST_NO_SPACE;
        end else if ({1'b0, first_free} >= MAX_I || !r_mark) begin
          st = ST_CHECK_FAILED;
        end else if (r_len == '0 || free_count == '0) begin
          st = ST_CHECK_FAILED;
        end else if (r_len != 11'd1 && nh >= MAX_I) begin
          st = ST_CHECK_FAILED;
        end else begin
          cnt_next = free_count - 11'd1;
          we_e     = 1'b1;
          if (r_len == 11'd1) begin
            ff_next = r_next;
            wa_e    = rd_addr;
            wd_e    = '0;
          end else begin
            ff_next = nh[IW-1:0];
            wa_e    = nh[IW-1:0];
            wd_e    = {1'b1, r_next, r_len - 11'd1};
            split   = 1'b1;
          end
        end
      end
      OP_FREE: begin
        if (!formatted) begin
          st = ST_NOT_FORMATTED;
        end else if (in_q.block_index == '0 ||
                     CW'(in_q.block_index) >= eff_w) begin
          st = ST_OUT_OF_RANGE;
        end else if (r_mark) begin
          st = ST_ALREADY_FREE;
        end else begin
          we_e    = 1'b1;
          wa_e    = rd_addr;
          wd_e    = {1'b1, first_free, 11'd1};
          ff_next = rd_addr;
          if (free_count < COUNT_MAX) begin
            cnt_next = free_count + 11'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt;
    wdata = '0;
    priority if (cmd.clear_step) begin
      we = 1'b1;
    end else if (cmd.eval) begin
      we    = we_e;
      waddr = wa_e;
      wdata = wd_e;
    end else if (cmd.write_head) begin
      we    = 1'b1;
      waddr = rd_addr;
    end else if (cmd.format_done) begin
      we    = 1'b1;
      waddr = IW'(1);
      wdata = {1'b1, {IW{1'b0}}, eff - 11'd1};
    end
  end

  assign raddr = (in_q.op == OP_FREE) ? IW'(in_q.block_index) : first_free;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.read_entry) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_q <= in_data;
    end
    if (cmd.read_entry) begin
      rd_addr <= raddr;
    end
    if (cmd.eval) begin
      res.allocated_block <= (st == ST_OK && in_q.op == OP_ALLOCATE) ? 10'(first_free) : '0;
      res.status          <= st;
      res.free_total      <= cnt_next;
    end else if (cmd.format_done) begin
      res.allocated_block <= '0;
      res.status          <= ST_OK;
      res.free_total      <= eff - 11'd1;
    end
    if (cmd.load_out) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume     <= VOLUME_RESET;
      formatted  <= 1'b0;
      first_free <= '0;
      free_count <= '0;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        volume <= cfg_data;
      end
      if (cmd.clear_step) begin
        clr_cnt <= (clr_cnt == LAST_A) ? '0 : clr_cnt + IW'(1);
      end
      if (cmd.eval) begin
        first_free <= ff_next;
        free_count <= cnt_next;
      end else if (cmd.format_done) begin
        formatted  <= 1'b1;
        first_free <= IW'(1);
        free_count <= eff - 11'd1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.in_is_format = (in_data.op == OP_FORMAT);
  assign stat.clear_last   = (clr_cnt == LAST_A);
  assign stat.split        = split;
  assign stat.out_free     = !out_valid || !out_stall;

endmodule

// ===== rtl/efl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Extent free list allocator controller
// Sequences the clearing pass, the table read, the updates and the hand-off
// of each result to the output register.
// ----------------------------------------------------------------------------
module efl_ctrl import efl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_HEAD  = 7'b0010000,
    S_FMT   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   fmt_pend;
  logic   fmt_pend_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    fmt_pend_next = fmt_pend;
    cmd           = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = fmt_pend ? S_FMT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          if (stat.in_is_format) begin
            fmt_pend_next = 1'b1;
            state_next    = S_CLEAR;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.read_entry = 1'b1;
        state_next     = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.split ? S_HEAD : S_OUT;
      end
      S_HEAD: begin
        cmd.write_head = 1'b1;
        state_next     = S_OUT;
      end
      S_FMT: begin
        cmd.format_done = 1'b1;
        fmt_pend_next   = 1'b0;
        state_next      = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      fmt_pend <= 1'b0;
    end else begin
      state    <= state_next;
      fmt_pend <= fmt_pend_next;
    end
  end

endmodule

// ===== rtl/extent_free_list_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Extent free list block allocator
// Keeps a linked free list of block runs and serves format, allocate and
// free operations, one result for each operation.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the run table, one entry a
// cycle, and accepts no operation until it is done. Allocate and free read
// the run table through its one read port, which has a registered
// output, and an allocate that shrinks a run writes two entries through the
// single write port. Format sweeps every table entry. One operation is in
// flight at a time; a finished result waits in the output register while the
// next operation is taken.
module extent_free_list_block_allocator_top import efl_pkg::*; #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  efl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  efl_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent free list block allocator testbench
// Drives format, allocate, free and unused operation codes through the input
// channel and predicts every result from a private copy of the free list, the
// free marks and the block count. The run starts with directed cases, then
// works through phases at several volume sizes with random operation mixes
// and, in most phases, random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import efl_pkg::*;

  localparam int MAX_BLOCKS = 1024;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int PHASE_ITEMS = 105;
  localparam int PHASE_COUNT = 9;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class free_list_scoreboard;
    logic [10:0] volume;
    logic [9:0]  head;
    logic [10:0] count;
    bit          formatted;
    bit          free_mark[MAX_BLOCKS];
    logic [9:0]  next_run[MAX_BLOCKS];
    logic [10:0] run_len[MAX_BLOCKS];
    out_item_t   awaited[$];
    int          errors;

    function new();
      volume = VOLUME_RESET;
      head = '0;
      count = '0;
      formatted = 1'b0;
      errors = 0;
      foreach (free_mark[i]) begin
        free_mark[i] = 1'b0;
        next_run[i] = '0;
        run_len[i] = '0;
      end
    endfunction

    function int unsigned eff_volume();
      if (volume < 2) begin
        return 2;
      end
      if (volume > MAX_BLOCKS) begin
        return MAX_BLOCKS;
      end
      return volume;
    endfunction

    function out_item_t note_op(in_item_t item);
      out_item_t   res;
      int unsigned vol;
      int unsigned cur;
      int unsigned len;
      int unsigned blk;
      logic [9:0]  got;
      got = '0;
      res.status = ST_OK;
      vol = eff_volume();
      case (item.op)
        OP_FORMAT: begin
          foreach (free_mark[i]) free_mark[i] = 1'b0;
          head = 10'd1;
          count = 11'(vol - 1);
          free_mark[1] = 1'b1;
          next_run[1] = '0;
          run_len[1] = 11'(vol - 1);
          formatted = 1'b1;
        end
        OP_ALLOCATE: begin
          cur = head;
          len = run_len[cur];
          if (!formatted) begin
            res.status = ST_NOT_FORMATTED;
          end else if (cur == 0) begin
            res.status = ST_NO_SPACE;
          end else if (cur >= MAX_BLOCKS || !free_mark[cur] || len == 0 || count == 0 ||
                       (len > 1 && cur + 1 >= MAX_BLOCKS)) begin
            res.status = ST_CHECK_FAILED;
          end else begin
            if (len == 1) begin
              head = next_run[cur];
            end else begin
              free_mark[cur + 1] = 1'b1;
              next_run[cur + 1] = next_run[cur];
              run_len[cur + 1] = 11'(len - 1);
              head = 10'(cur + 1);
            end
            count = count - 11'd1;
            free_mark[cur] = 1'b0;
            got = 10'(cur);
          end
        end
        OP_FREE: begin
          blk = item.block_index;
          if (!formatted) begin
            res.status = ST_NOT_FORMATTED;
          end else if (blk == 0 || blk >= vol) begin
            res.status = ST_OUT_OF_RANGE;
          end else if (free_mark[blk]) begin
            res.status = ST_ALREADY_FREE;
          end else begin
            free_mark[blk] = 1'b1;
            next_run[blk] = head;
            run_len[blk] = 11'd1;
            head = 10'(blk);
            if (count < COUNT_MAX) begin
              count = count + 11'd1;
            end
          end
        end
        default: ;
      endcase
      res.allocated_block = got;
      res.free_total = count;
      awaited.push_back(res);
      return res;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic [10:0] got, logic [10:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
      end
    endtask

    task check_outcome(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result transfer with no operation outstanding");
      end else begin
        want = awaited.pop_front();
        compare_field("allocated_block", 11'(got.allocated_block), 11'(want.allocated_block));
        compare_field("status", 11'(got.status), 11'(want.status));
        compare_field("free_total", got.free_total, want.free_total);
      end
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  free_list_scoreboard tracker = new();
  logic [9:0]  held_blocks[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_requests = 0;
  int          holds_taken = 0;
  logic [10:0] phase_volume[PHASE_COUNT] = '{11'd2047, 11'd2, 11'd0, 11'd1024, 11'd1,
                                              11'd17, 11'd1024, 11'd1536, 11'd300};

  extent_free_list_block_allocator_top #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_op(logic [1:0] op, logic [9:0] blk);
    in_item_t  item;
    out_item_t pred;
    item.op = op;
    item.block_index = blk;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    pred = tracker.note_op(item);
    if (op == OP_FORMAT) begin
      held_blocks.delete();
    end else if (op == OP_ALLOCATE && pred.status == ST_OK) begin
      held_blocks.push_back(pred.allocated_block);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_volume(logic [10:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.volume = value;
  endtask

  task automatic random_phase(int n, bit start_with_format, bit long_hold);
    int unsigned r;
    int unsigned vol;
    int unsigned k;
    logic [1:0]  op;
    logic [9:0]  blk;
    if (start_with_format) begin
      send_op(OP_FORMAT, 10'($urandom_range(1023)));
    end
    for (int i = 0; i < n; i++) begin
      if (long_hold && i == n / 4) begin
        hold_requests++;
      end
      if (i == n / 2) begin
        wait_drained();
      end
      r = $urandom_range(99);
      vol = tracker.eff_volume();
      blk = 10'($urandom_range(1023));
      if (r < 2) begin
        op = OP_FORMAT;
      end else if (r < 5) begin
        op = OP_UNUSED;
      end else if (r < 50) begin
        op = OP_ALLOCATE;
      end else begin
        op = OP_FREE;
        r = $urandom_range(99);
        if (r < 60 && held_blocks.size() != 0) begin
          k = $urandom_range(held_blocks.size() - 1);
          blk = held_blocks[k];
          held_blocks.delete(k);
        end else if (r < 80) begin
          blk = 10'($urandom_range(vol - 1, 1));
        end else if (r < 85) begin
          blk = '0;
        end else if (r < 92 && vol < MAX_BLOCKS) begin
          blk = 10'($urandom_range(MAX_BLOCKS - 1, vol));
        end
      end
      send_op(op, blk);
    end
  endtask

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        tracker.check_outcome(out_data);
      end
      if (holds_taken != hold_requests) begin
        holds_taken = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 65;
    write_volume(VOLUME_RESET);

    send_op(OP_ALLOCATE, 10'd0);
    send_op(OP_FREE, 10'd5);
    send_op(OP_UNUSED, 10'd1023);
    send_op(OP_FORMAT, 10'd0);
    send_op(OP_ALLOCATE, 10'd0);
    send_op(OP_ALLOCATE, 10'd1023);
    send_op(OP_FREE, 10'd1);
    send_op(OP_FREE, 10'd1);
    send_op(OP_FREE, 10'd0);
    send_op(OP_FREE, 10'd1023);
    send_op(OP_FREE, 10'd1023);
    send_op(OP_ALLOCATE, 10'd0);
    send_op(OP_ALLOCATE, 10'd0);
    send_op(OP_ALLOCATE, 10'd0);
    send_op(OP_FREE, 10'd600);
    send_op(OP_ALLOCATE, 10'd0);
    wait_drained();
    write_volume(11'd2);
    send_op(OP_FREE, 10'd1);
    send_op(OP_FORMAT, 10'd1023);
    send_op(OP_ALLOCATE, 10'd0);
    send_op(OP_ALLOCATE, 10'd0);
    send_op(OP_FREE, 10'd2);
    send_op(OP_FREE, 10'd1023);
    send_op(OP_FREE, 10'd1);
    send_op(OP_FREE, 10'd1);
    send_op(OP_ALLOCATE, 10'd0);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 30;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      if (p == PHASE_COUNT - 1) begin
        write_volume(11'($urandom_range(MAX_BLOCKS, 2)));
      end else begin
        write_volume(phase_volume[p]);
      end
      random_phase(PHASE_ITEMS, p != 4, p == 1 || p == 7);
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
